>>> rtl/drb_pkg.sv
// ----------------------------------------------------------------------------
// drb_pkg
// Types, constants and codes shared by the damped resonator bank.
// ----------------------------------------------------------------------------
package drb_pkg;

  localparam int unsigned NUM_RESONATORS_DEF = 16;
  localparam logic [31:0] K4PI2 = 32'd662337939;

  localparam logic [31:0] TIME_STEP_RST = 32'd97391;
  localparam logic [31:0] DAMPING_RST   = 32'd16777216;
  localparam logic [15:0] WINDOW_RST    = 16'd1024;
  localparam logic [4:0]  ACTIVE_RST    = 5'd16;

  localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48 = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_WINDOW    = 3'd2,
    REG_ACTIVE    = 3'd3,
    REG_EMIT      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic signed [15:0] sample_value;
    logic [3:0]  resonator_index;
    logic [31:0] stiffness_coef;
    logic [39:0] weight_coef;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  resonator_id;
    logic signed [47:0] result_value;
    logic [15:0] window_number;
    logic [31:0] peak_rms;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_RD, S_ISSUE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_EN, S_POS, S_WAITP, S_NEXT, S_RD2, S_DIV, S_SQRT, S_RMS, S_WAITR
  } state_t;

  // multiplier op request: signed operand times unsigned operand, shift
  typedef struct packed {
    logic        start;
    logic signed [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
  } mul_req_t;

endpackage

>>> rtl/damped_resonator_bank_rms_top.sv
// ----------------------------------------------------------------------------
// damped_resonator_bank_rms_top
// Resonator bank with windowed RMS on one shared multiplier.
// ----------------------------------------------------------------------------
// Each sample runs six passes of the shared multiplier per active resonator,
// plus the state steps; emitted positions add an output step and its wait.
// A window end adds, per resonator, a restoring divide of the energy by the
// window length and a square root, plus output waits. Loads are written from
// the idle state. Clear sweeps the state memories. Reset leaves registers at
// defaults and runs the same sweep; no item is taken meanwhile.
module damped_resonator_bank_rms_top #(
  parameter int unsigned NUM_RESONATORS = drb_pkg::NUM_RESONATORS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  drb_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output drb_pkg::out_item_t out_data,
  input  logic cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import drb_pkg::*;

  localparam int IW = (NUM_RESONATORS > 1) ? $clog2(NUM_RESONATORS) : 1;

  logic [31:0] time_step, damping_factor;
  logic [15:0] window_length;
  logic [4:0]  active_resonators;
  logic        emit_positions;

  logic signed [47:0] pos_mem [NUM_RESONATORS];
  logic signed [47:0] vel_mem [NUM_RESONATORS];
  logic [63:0] en_mem [NUM_RESONATORS];
  logic [31:0] stf_mem [NUM_RESONATORS];
  logic [39:0] wgt_mem [NUM_RESONATORS];

  state_t state, state_next;
  logic [IW-1:0] idx;
  logic [IW:0]   nact;
  logic [15:0]   wl, window_fill, window_counter;
  logic [31:0]   max_rms_seen;
  logic signed [47:0] samp, p, v, np, a, f, y;
  logic [63:0] en, rem, quo, sq_v, sq_res, sq_bit, sq_cur;
  logic [31:0] stf;
  logic [39:0] wgt;
  logic [6:0]  cnt;
  logic        win_end;
  logic        sweep;
  mul_req_t    mreq;
  logic        mdone;
  logic signed [47:0] mres;
  logic [127:0] mprod;
  logic [64:0] rtrial;
  logic [31:0] rms;

  drb_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .res(mres), .prod(mprod));

  function automatic logic signed [47:0] sat(input logic signed [49:0] x);
    if (x > $signed({2'b00, MAX48})) return MAX48;
    if (x < $signed({2'b11, MIN48})) return MIN48;
    return x[47:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      damping_factor <= DAMPING_RST;
      window_length <= WINDOW_RST;
      active_resonators <= ACTIVE_RST;
      emit_positions <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TIME_STEP: time_step <= cfg_data;
        REG_DAMPING: damping_factor <= cfg_data;
        REG_WINDOW: window_length <= cfg_data[15:0];
        REG_ACTIVE: active_resonators <= cfg_data[4:0];
        REG_EMIT: emit_positions <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign rtrial = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_cur = (cnt == 7'd0) ? quo : sq_v;

  always_comb begin
    mreq = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        unique case (opcode_t'(in_data.opcode))
          OP_SAMPLE: state_next = S_RD;
          OP_CLEAR: state_next = S_CLEAR;
          default: state_next = S_IDLE;
        endcase
      end
      S_CLEAR: if (idx == IW'(NUM_RESONATORS - 1)) state_next = S_IDLE;
      S_RD: state_next = S_ISSUE;
      S_ISSUE: begin
        mreq.start = 1'b1; mreq.a = 64'(v); mreq.b = {32'd0, time_step}; mreq.sh = 6'd32;
        state_next = S_M1;
      end
      S_M1: if (mdone) begin
        mreq.start = 1'b1; mreq.a = 64'(p); mreq.b = {32'd0, K4PI2}; mreq.sh = 6'd24;
        state_next = S_M2;
      end
      S_M2: if (mdone) begin
        mreq.start = 1'b1; mreq.a = 64'(v); mreq.b = {32'd0, damping_factor};
        mreq.sh = 6'd24;
        state_next = S_M3;
      end
      S_M3: if (mdone) begin
        mreq.start = 1'b1; mreq.a = 64'(sat(50'(a) + 50'(mres))); mreq.b = {32'd0, stf};
        mreq.sh = 6'd16;
        state_next = S_M4;
      end
      S_M4: if (mdone) begin
        mreq.start = 1'b1; mreq.a = 64'(np); mreq.b = {24'd0, wgt}; mreq.sh = 6'd0;
        state_next = S_M5;
      end
      S_M5: if (mdone) begin
        mreq.start = 1'b1; mreq.a = mres[47] ? 64'd0 - 64'(mres) : 64'(mres);
        mreq.a = {16'd0, mreq.a[47:0]};
        mreq.b = mreq.a; mreq.sh = 6'd0;
        state_next = S_M6;
      end
      S_M6: if (mdone) state_next = S_EN;
      S_EN: state_next = emit_positions ? S_POS : S_NEXT;
      S_POS: state_next = S_WAITP;
      S_WAITP: if (!out_stall) state_next = S_NEXT;
      S_NEXT: begin
        if ({1'b0, idx} + 1'b1 < nact) state_next = S_RD;
        else if (win_end) state_next = S_RD2;
        else state_next = S_IDLE;
      end
      S_RD2: state_next = S_DIV;
      S_DIV: if (cnt == 7'd63) state_next = S_SQRT;
      S_SQRT: if (cnt == 7'd31) state_next = S_RMS;
      S_RMS: state_next = S_WAITR;
      S_WAITR: if (!out_stall) begin
        state_next = ({1'b0, idx} + 1'b1 < nact) ? S_RD2 : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rms = sq_res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      out_valid <= 1'b0;
      window_fill <= '0;
      window_counter <= '0;
      max_rms_seen <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          idx <= '0;
          samp <= 48'(in_data.sample_value) <<< 9;
          nact <= (active_resonators == 5'd0) ? (IW+1)'(1) :
                  ({1'b0, active_resonators} > 6'(NUM_RESONATORS)) ?
                  (IW+1)'(NUM_RESONATORS) : (IW+1)'(active_resonators);
          wl <= (window_length == 16'd0) ? 16'd1 : window_length;
          if (opcode_t'(in_data.opcode) == OP_LOAD &&
              {2'b00, in_data.resonator_index} < 6'(NUM_RESONATORS)) begin
            stf_mem[IW'(in_data.resonator_index)] <= in_data.stiffness_coef;
            wgt_mem[IW'(in_data.resonator_index)] <= in_data.weight_coef;
          end
          if (opcode_t'(in_data.opcode) == OP_CLEAR) begin
            window_fill <= '0; window_counter <= '0; max_rms_seen <= '0;
          end
        end
        S_CLEAR: begin
          pos_mem[idx] <= '0; vel_mem[idx] <= '0; en_mem[idx] <= '0;
          idx <= (idx == IW'(NUM_RESONATORS - 1)) ? '0 : idx + 1'b1;
        end
        S_RD: begin
          p <= pos_mem[idx]; v <= vel_mem[idx]; en <= en_mem[idx];
          stf <= stf_mem[idx]; wgt <= wgt_mem[idx];
        end
        S_M1: if (mdone) np <= sat(50'(p) + 50'(mres));
        S_M2: if (mdone) a <= mres;
        S_M4: if (mdone) f <= mres;
        S_M5: if (mdone) y <= mres;
        S_M6: if (mdone) begin
          if (mprod[127:80] != '0) sq_v <= '1;
          else sq_v <= mprod[79:16];
        end
        S_EN: begin
          pos_mem[idx] <= np;
          vel_mem[idx] <= sat(50'(samp) + 50'(v) - 50'(f));
          en_mem[idx] <= ({1'b0, en} + {1'b0, sq_v} > 65'h0_FFFF_FFFF_FFFF_FFFF) ?
                         '1 : en + sq_v;
          if ({1'b0, idx} + 1'b1 >= nact) win_end <= ({1'b0, window_fill} + 17'd1 >= {1'b0, wl});
        end
        S_POS: begin
          out_valid <= 1'b1;
          out_data <= '{1'b0, 4'(idx), y, window_counter, max_rms_seen,
                        ({1'b0, idx} + 1'b1 >= nact) &&
                        !({1'b0, window_fill} + 17'd1 >= {1'b0, wl})};
        end
        S_NEXT: begin
          if ({1'b0, idx} + 1'b1 < nact) idx <= idx + 1'b1;
          else begin
            idx <= '0;
            if (win_end) window_fill <= '0;
            else window_fill <= window_fill + 16'd1;
          end
        end
        S_RD2: begin
          rem <= '0; quo <= en_mem[idx]; cnt <= '0;
          en_mem[idx] <= '0;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if ({rem[62:0], quo[63]} >= {48'd0, wl}) begin
            rem <= {rem[62:0], quo[63]} - {48'd0, wl};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], quo[63]};
            quo <= {quo[62:0], 1'b0};
          end
          if (cnt == 7'd63) begin
            sq_res <= '0; sq_bit <= 64'd1 << 62; cnt <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_SQRT: begin
          if ({1'b0, sq_cur} >= rtrial) begin
            sq_v <= sq_cur - rtrial[63:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_v <= sq_cur;
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 7'd1;
        end
        S_RMS: begin
          out_valid <= 1'b1;
          out_data <= '{1'b1, 4'(idx), 48'(rms),
                        window_counter,
                        (rms > max_rms_seen) ? rms : max_rms_seen,
                        ({1'b0, idx} + 1'b1 >= nact)};
          if (rms > max_rms_seen) max_rms_seen <= rms;
        end
        S_WAITR: if (!out_stall) begin
          if ({1'b0, idx} + 1'b1 < nact) idx <= idx + 1'b1;
          else begin
            idx <= '0;
            window_counter <= window_counter + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign sweep = (state == S_CLEAR);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_no_out_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep |-> !out_valid) else $error("result during clear sweep");
  a_rms_peak: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind) |-> (out_data.result_value[47:32] == 16'd0))
    else $error("rms out of range");

endmodule

>>> rtl/drb_mul.sv
// ----------------------------------------------------------------------------
// drb_mul
// Shared signed-by-unsigned multiplier, 16x16 partial product per cycle,
// with magnitude truncating shift and 48-bit saturation.
// ----------------------------------------------------------------------------
module drb_mul (
  input  logic clk,
  input  logic rst,
  input  drb_pkg::mul_req_t req,
  output logic done,
  output logic signed [47:0] res,
  output logic [127:0] prod
);
  import drb_pkg::*;

  logic         busy;
  logic         neg;
  logic [63:0]  ma, mb;
  logic [127:0] acc;
  logic [1:0]   ia, ib;
  logic [5:0]   sh;
  logic [31:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] q;
  logic [47:0]  lim;

  always_comb begin
    pp = {16'd0, ma[ia*16 +: 16]} * {16'd0, mb[ib*16 +: 16]};
    pp_sh = {96'd0, pp} << ({5'd0, ia} + {5'd0, ib}) * 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        neg  <= req.a[63];
        ma   <= req.a[63] ? 64'd0 - req.a : req.a;
        mb   <= req.b;
        sh   <= req.sh;
        acc  <= '0;
        ia   <= '0;
        ib   <= '0;
      end else if (busy) begin
        acc <= acc + pp_sh;
        ib  <= ib + 2'd1;
        if (ib == 2'd3) begin
          ia <= ia + 2'd1;
          if (ia == 2'd3) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    q = acc >> sh;
    lim = neg ? MIN48 : MAX48;
    prod = acc;
    if (q[127:48] != '0 || q[47:0] > lim) res = neg ? MIN48 : MAX48;
    else res = neg ? 48'd0 - q[47:0] : q[47:0];
  end

endmodule
